// ----- design/psa_pkg.sv -----
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and codes for the paged slot allocator: opcodes, status
// codes, controller states and the update-to-control handoff.
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam int CFG_W   = 7;
    localparam int IDX_W   = 6;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_PAGE   = 2'd1,
        STAT_BAD_INDEX = 2'd2,
        STAT_NOT_OCC   = 2'd3
    } psa_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } psa_state_t;

    typedef enum logic [1:0] {
        HEAD_KEEP,
        HEAD_LINK,
        HEAD_PAGE
    } psa_head_sel_t;

    typedef struct packed {
        psa_status_t   status;
        logic          write;
        logic          open_page;
        psa_head_sel_t head_sel;
    } psa_ctl_t;

endpackage

// ----- design/psa_ram.sv -----
// ----------------------------------------------------------------------------
// psa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module psa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/psa_update.sv -----
// ----------------------------------------------------------------------------
// psa_update
// Page entry update: takes the entry read from page memory (or a freshly
// opened page), claims or frees a slot and decides status and list moves.
// ----------------------------------------------------------------------------
module psa_update #(
    parameter int PAGES  = 64,
    parameter int SLOTS  = 64,
    localparam int PW    = $clog2(PAGES),
    localparam int SW    = $clog2(SLOTS),
    localparam int CW    = ((PW + 1) > 6) ? (PW + 1) : 6
) (
    input  logic                         op,
    input  logic [psa_pkg::IDX_W-1:0]    pidx,
    input  logic [psa_pkg::IDX_W-1:0]    sidx,
    input  logic [PW:0]                  head,
    input  logic [PW:0]                  piu,
    input  logic [psa_pkg::CFG_W-1:0]    spp,
    input  logic [SLOTS-1:0]             rd_occ,
    input  logic [psa_pkg::COUNT_W-1:0]  rd_cnt,
    input  logic [PW:0]                  rd_link,
    input  logic                         rd_on,
    output psa_pkg::psa_ctl_t            ctl,
    output logic [PW-1:0]                wr_page,
    output logic [SLOTS-1:0]             wr_occ,
    output logic [psa_pkg::COUNT_W-1:0]  wr_cnt,
    output logic [PW:0]                  wr_link,
    output logic                         wr_on,
    output logic [psa_pkg::IDX_W-1:0]    res_page,
    output logic [psa_pkg::IDX_W-1:0]    res_slot
);

    logic [psa_pkg::CFG_W-1:0]   n;
    logic [SLOTS-1:0]            mask;
    logic                        list_empty;
    logic [SLOTS-1:0]            occ_c;
    logic [psa_pkg::COUNT_W-1:0] cnt_c;
    logic [PW:0]                 link_c;
    logic [PW-1:0]               ins_page;
    logic [SLOTS-1:0]            free_c;
    logic [SW-1:0]               ff;
    logic [SLOTS-1:0]            occ_s;
    logic [psa_pkg::COUNT_W-1:0] cnt_s;
    logic                        full_after;
    logic                        del_range_bad;
    logic                        del_bit;
    logic [SW-1:0]               del_sl;

    // Clamp the slot count to 1..SLOTS
    always_comb
    begin
        if (spp == '0)
            n = psa_pkg::CFG_W'(1);
        else if (spp > psa_pkg::CFG_W'(SLOTS))
            n = psa_pkg::CFG_W'(SLOTS);
        else
            n = spp;
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            mask[i] = (psa_pkg::CFG_W'(i) < n);
        end
    end

    assign list_empty = (head >= (PW + 1)'(PAGES));
    assign occ_c      = list_empty ? '0 : rd_occ;
    assign cnt_c      = list_empty ? '0 : rd_cnt;
    assign link_c     = list_empty ? head : rd_link;
    assign ins_page   = list_empty ? piu[PW-1:0] : head[PW-1:0];
    assign free_c     = ~occ_c & mask;

    // Lowest free slot
    always_comb
    begin
        ff = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (free_c[i])
                ff = SW'(i);
        end
    end

    assign occ_s      = occ_c | (SLOTS'(1) << ff);
    assign cnt_s      = cnt_c + psa_pkg::COUNT_W'(1);
    assign full_after = (cnt_s >= psa_pkg::COUNT_W'(n)) || ((~occ_s & mask) == '0);

    assign del_range_bad = (CW'(pidx) >= CW'(piu)) || (psa_pkg::CFG_W'(sidx) >= n);
    assign del_sl        = sidx[SW-1:0];
    assign del_bit       = rd_occ[del_sl];

    always_comb
    begin
        ctl.status    = psa_pkg::STAT_OK;
        ctl.write     = 1'b0;
        ctl.open_page = 1'b0;
        ctl.head_sel  = psa_pkg::HEAD_KEEP;
        wr_page       = ins_page;
        wr_occ        = occ_c;
        wr_cnt        = cnt_c;
        wr_link       = link_c;
        wr_on         = 1'b1;
        res_page      = pidx;
        res_slot      = sidx;

        if (op == psa_pkg::OP_INSERT)
        begin
            res_page = psa_pkg::IDX_W'(ins_page);
            res_slot = '0;
            if (list_empty && (piu >= (PW + 1)'(PAGES)))
            begin
                ctl.status = psa_pkg::STAT_NO_PAGE;
                res_page   = '0;
            end
            else
            begin
                ctl.write     = 1'b1;
                ctl.open_page = list_empty;
                if (list_empty)
                    ctl.head_sel = psa_pkg::HEAD_PAGE;
                if ((free_c == '0) || (cnt_c >= psa_pkg::COUNT_W'(n)))
                begin
                    // Head page has no room left: drop it from the list
                    ctl.status   = psa_pkg::STAT_NO_PAGE;
                    ctl.head_sel = psa_pkg::HEAD_LINK;
                    wr_on        = 1'b0;
                end
                else
                begin
                    wr_occ   = occ_s;
                    wr_cnt   = cnt_s;
                    res_slot = psa_pkg::IDX_W'(ff);
                    if (full_after)
                    begin
                        ctl.head_sel = psa_pkg::HEAD_LINK;
                        wr_on        = 1'b0;
                    end
                end
            end
        end
        else
        begin
            wr_page = PW'(pidx);
            if (del_range_bad)
            begin
                ctl.status = psa_pkg::STAT_BAD_INDEX;
            end
            else if (!del_bit)
            begin
                ctl.status = psa_pkg::STAT_NOT_OCC;
            end
            else
            begin
                ctl.write = 1'b1;
                wr_occ    = rd_occ & ~(SLOTS'(1) << del_sl);
                wr_cnt    = (rd_cnt == '0) ? '0 : (rd_cnt - psa_pkg::COUNT_W'(1));
                wr_link   = rd_on ? rd_link : head;
                wr_on     = 1'b1;
                // A page that was full goes back on the list head
                if (!rd_on)
                    ctl.head_sel = psa_pkg::HEAD_PAGE;
            end
        end
    end

endmodule

// ----- design/paged_slot_allocator_core.sv -----
// ----------------------------------------------------------------------------
// paged_slot_allocator_core
// Two-level slot allocator: per-page occupancy bitmaps in memory plus a
// linked list of pages that still have free slots.
// ----------------------------------------------------------------------------
// Each request has a read step and a write step: the page entry is read from
// the single page memory in the cycle the request is accepted, then updated
// and written back in the next cycle, while busy is high. The result is
// registered from the write step and appears on status, page_out and slot_out
// with done high for exactly one cycle; it cannot be stalled, so the receiver
// must take it then. A new request may be accepted in the cycle the previous
// result is shown. No clearing pass is needed after reset: a page entry is
// written when the page is first opened, before it is ever read.
module paged_slot_allocator_core #(
    parameter int PAGES = 64,
    parameter int SLOTS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        opcode,
    input  logic [psa_pkg::IDX_W-1:0]   page_index,
    input  logic [psa_pkg::IDX_W-1:0]   slot_index,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [psa_pkg::IDX_W-1:0]   page_out,
    output logic [psa_pkg::IDX_W-1:0]   slot_out,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [psa_pkg::CFG_W-1:0]   cfg_data
);

    localparam int PW = $clog2(PAGES);
    localparam int EW = SLOTS + psa_pkg::COUNT_W + (PW + 1) + 1;

    psa_pkg::psa_state_t          state_reg, state_next;
    logic                         op_reg;
    logic [psa_pkg::IDX_W-1:0]    pidx_reg;
    logic [psa_pkg::IDX_W-1:0]    sidx_reg;
    logic [PW:0]                  head_reg, head_next;
    logic [PW:0]                  piu_reg, piu_next;
    logic [psa_pkg::CFG_W-1:0]    spp_reg;
    logic                         done_reg;
    psa_pkg::psa_status_t         status_reg;
    logic [psa_pkg::IDX_W-1:0]    page_out_reg;
    logic [psa_pkg::IDX_W-1:0]    slot_out_reg;

    logic                         accept;
    logic                         rd_en;
    logic                         exec;
    logic [PW-1:0]                rd_addr;
    logic [EW-1:0]                rd_data;
    logic [EW-1:0]                wr_data;

    logic [SLOTS-1:0]             rd_occ;
    logic [psa_pkg::COUNT_W-1:0]  rd_cnt;
    logic [PW:0]                  rd_link;
    logic                         rd_on;

    psa_pkg::psa_ctl_t            ctl;
    logic [PW-1:0]                wr_page;
    logic [SLOTS-1:0]             wr_occ;
    logic [psa_pkg::COUNT_W-1:0]  wr_cnt;
    logic [PW:0]                  wr_link;
    logic                         wr_on;
    logic [psa_pkg::IDX_W-1:0]    res_page;
    logic [psa_pkg::IDX_W-1:0]    res_slot;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psa_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = psa_pkg::ST_EXEC;
            end
            psa_pkg::ST_EXEC:
            begin
                state_next = psa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = psa_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        busy  = 1'b0;
        rd_en = 1'b0;
        exec  = 1'b0;
        unique case (state_reg)
            psa_pkg::ST_IDLE:
            begin
                rd_en = start;
            end
            psa_pkg::ST_EXEC:
            begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign rd_addr = (opcode == psa_pkg::OP_INSERT) ? head_reg[PW-1:0] : PW'(page_index);

    psa_ram #(
        .WIDTH (EW),
        .DEPTH (PAGES)
    ) u_page_ram (
        .clk   (clk),
        .we    (exec && ctl.write),
        .waddr (wr_page),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign {rd_occ, rd_cnt, rd_link, rd_on} = rd_data;
    assign wr_data = {wr_occ, wr_cnt, wr_link, wr_on};

    psa_update #(
        .PAGES (PAGES),
        .SLOTS (SLOTS)
    ) u_update (
        .op       (op_reg),
        .pidx     (pidx_reg),
        .sidx     (sidx_reg),
        .head     (head_reg),
        .piu      (piu_reg),
        .spp      (spp_reg),
        .rd_occ   (rd_occ),
        .rd_cnt   (rd_cnt),
        .rd_link  (rd_link),
        .rd_on    (rd_on),
        .ctl      (ctl),
        .wr_page  (wr_page),
        .wr_occ   (wr_occ),
        .wr_cnt   (wr_cnt),
        .wr_link  (wr_link),
        .wr_on    (wr_on),
        .res_page (res_page),
        .res_slot (res_slot)
    );

    always_comb
    begin
        head_next = head_reg;
        piu_next  = piu_reg;
        if (exec)
        begin
            case (ctl.head_sel)
                psa_pkg::HEAD_LINK: head_next = wr_link;
                psa_pkg::HEAD_PAGE: head_next = {1'b0, wr_page};
                default:            head_next = head_reg;
            endcase
            if (ctl.open_page)
                piu_next = piu_reg + (PW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psa_pkg::ST_IDLE;
            head_reg  <= (PW + 1)'(PAGES);
            piu_reg   <= '0;
            spp_reg   <= psa_pkg::CFG_W'(64);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            piu_reg   <= piu_next;
            done_reg  <= exec;
            if (cfg_valid && cfg_ready)
                spp_reg <= cfg_data;
        end
    end

    // Hold the request and the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            pidx_reg <= page_index;
            sidx_reg <= slot_index;
        end
        if (exec)
        begin
            status_reg   <= ctl.status;
            page_out_reg <= res_page;
            slot_out_reg <= res_slot;
        end
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign page_out = page_out_reg;
    assign slot_out = slot_out_reg;

endmodule

// ----- design/psa_checker.sv -----
// ----------------------------------------------------------------------------
// psa_checker
// Port-level checks on request and result timing of the slot allocator.
// ----------------------------------------------------------------------------
module psa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] status
);

    logic accepted;
    logic status_known;

    assign accepted     = start && !busy;
    assign status_known = !$isunknown(status);

    // Busy for exactly one cycle after a request
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accepted |=> busy)
        else $error("busy not raised after accepted request");

    a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // Every request gives exactly one result
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        accepted |-> ##2 (done && status_known))
        else $error("missing result for accepted request");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accepted, 2))
        else $error("result without matching request");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

endmodule

bind paged_slot_allocator_core psa_checker u_psa_checker (.*);

// ----- tb/psa_alloc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_alloc_checker
// Watches the request, result and config channels of the paged slot
// allocator. Keeps its own copy of the page table and the free-page list,
// predicts the result of every accepted request and compares it with the
// result strobed back.
// ----------------------------------------------------------------------------
module psa_alloc_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        opcode,
    input  logic [psa_pkg::IDX_W-1:0]   page_index,
    input  logic [psa_pkg::IDX_W-1:0]   slot_index,
    input  logic                        done,
    input  logic [1:0]                  status,
    input  logic [psa_pkg::IDX_W-1:0]   page_out,
    input  logic [psa_pkg::IDX_W-1:0]   slot_out,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [psa_pkg::CFG_W-1:0]   cfg_data,
    output int                          mismatch_count,
    output int                          results_due
);
    import psa_pkg::*;

    localparam int NUM_PAGES = 64;
    localparam int MAX_SLOTS = 64;
    localparam logic [COUNT_W-1:0] LIST_END = 7'd64;

    typedef struct packed {
        psa_status_t        status;
        logic [IDX_W-1:0]   page;
        logic [IDX_W-1:0]   slot;
    } alloc_result_t;

    logic [63:0]        occ_bits   [NUM_PAGES];
    logic [COUNT_W-1:0] used_slots [NUM_PAGES];
    logic [COUNT_W-1:0] next_link  [NUM_PAGES];
    logic               on_list    [NUM_PAGES];
    logic [COUNT_W-1:0] list_head;
    logic [COUNT_W-1:0] pages_opened;
    logic [CFG_W-1:0]   slots_per_page;
    alloc_result_t      pending_allocs [$];

    function automatic int active_slots();
        if (slots_per_page < 1)
            return 1;
        if (slots_per_page > MAX_SLOTS)
            return MAX_SLOTS;
        return int'(slots_per_page);
    endfunction

    // lowest clear bit below n, 64 when the page has none
    function automatic int lowest_free(logic [63:0] bits, int n);
        logic [63:0] avail;
        avail = ~bits & ((n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1));
        for (int i = 0; i < 64; i++)
        begin
            if (avail[i])
                return i;
        end
        return 64;
    endfunction

    function automatic alloc_result_t predict_alloc(logic op, logic [IDX_W-1:0] pg_in,
                                                    logic [IDX_W-1:0] sl_in);
        alloc_result_t res;
        int n;
        int pg;
        int sl;
        n = active_slots();
        if (op == OP_INSERT)
        begin
            if (list_head >= LIST_END)
            begin
                if (pages_opened >= LIST_END)
                begin
                    res = '{STAT_NO_PAGE, 6'd0, 6'd0};
                    return res;
                end
                // open the next unused page and push it on the list
                pg = int'(pages_opened);
                occ_bits[pg]   = '0;
                used_slots[pg] = '0;
                next_link[pg]  = list_head;
                on_list[pg]    = 1'b1;
                list_head      = pages_opened;
                pages_opened   = pages_opened + 1'b1;
            end
            pg = int'(list_head);
            sl = lowest_free(occ_bits[pg], n);
            if (sl >= 64 || used_slots[pg] >= n)
            begin
                // head page became full after the slot count was lowered: drop it
                list_head   = next_link[pg];
                on_list[pg] = 1'b0;
                res = '{STAT_NO_PAGE, 6'(pg), 6'd0};
                return res;
            end
            occ_bits[pg][sl] = 1'b1;
            used_slots[pg]   = used_slots[pg] + 1'b1;
            if (used_slots[pg] >= n || lowest_free(occ_bits[pg], n) >= 64)
            begin
                list_head   = next_link[pg];
                on_list[pg] = 1'b0;
            end
            res = '{STAT_OK, 6'(pg), 6'(sl)};
            return res;
        end
        pg = int'(pg_in);
        sl = int'(sl_in);
        if (pg >= pages_opened || sl >= n)
        begin
            res = '{STAT_BAD_INDEX, pg_in, sl_in};
            return res;
        end
        if (!occ_bits[pg][sl])
        begin
            res = '{STAT_NOT_OCC, pg_in, sl_in};
            return res;
        end
        occ_bits[pg][sl] = 1'b0;
        if (used_slots[pg] > 0)
            used_slots[pg] = used_slots[pg] - 1'b1;
        if (!on_list[pg])
        begin
            next_link[pg] = list_head;
            list_head     = 7'(pg);
            on_list[pg]   = 1'b1;
        end
        res = '{STAT_OK, pg_in, sl_in};
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        alloc_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PAGES; i++)
            begin
                occ_bits[i]   = '0;
                used_slots[i] = '0;
                next_link[i]  = '0;
                on_list[i]    = 1'b0;
            end
            list_head      = LIST_END;
            pages_opened   = '0;
            slots_per_page = 7'd64;
            pending_allocs.delete();
            mismatch_count = 0;
            results_due    = 0;
        end
        else
        begin
            // retire the oldest request before taking a new one
            if (done)
            begin
                if (pending_allocs.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with no request: status=%0d page=%0d slot=%0d",
                                 $time, status, page_out, slot_out);
                end
                else
                begin
                    want = pending_allocs.pop_front();
                    if (status !== want.status || page_out !== want.page ||
                        slot_out !== want.slot)
                    begin
                        mismatch_count++;
                        // values are status/page/slot
                        if (mismatch_count <= 10)
                            $display("%0t: mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     $time, want.status, want.page, want.slot,
                                     status, page_out, slot_out);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                slots_per_page = cfg_data;
            if (start && !busy)
                pending_allocs.push_back(predict_alloc(opcode, page_index, slot_index));
            results_due = pending_allocs.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the paged slot allocator with a directed walk through the list and
// error cases, then random insert/delete traffic under several slot counts
// and idle patterns. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import psa_pkg::*;

    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 90;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                opcode;
    logic [IDX_W-1:0]    page_index;
    logic [IDX_W-1:0]    slot_index;
    logic                done;
    logic [1:0]          status;
    logic [IDX_W-1:0]    page_out;
    logic [IDX_W-1:0]    slot_out;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data;
    int                  mismatch_count;
    int                  results_due;
    int                  hi_page = 0;
    int                  hi_slot = 0;

    paged_slot_allocator_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .page_index (page_index),
        .slot_index (slot_index),
        .done       (done),
        .status     (status),
        .page_out   (page_out),
        .slot_out   (slot_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    psa_alloc_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .page_index     (page_index),
        .slot_index     (slot_index),
        .done           (done),
        .status         (status),
        .page_out       (page_out),
        .slot_out       (slot_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("tb failed");
        $finish;
    end

    // track the highest slot and page handed out, to aim deletes at live slots
    always @(posedge clk)
    begin
        if (rst_n && done && status == STAT_OK)
        begin
            if (page_out > hi_page)
                hi_page = page_out;
            if (slot_out > hi_slot)
                hi_slot = slot_out;
        end
    end

    function automatic int pick_gap(int idle_pct);
        if ($urandom_range(0, 99) >= idle_pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(5, 20);
        return $urandom_range(1, 4);
    endfunction

    function automatic int clamp_slots(int v);
        if (v < 1)
            return 1;
        if (v > 64)
            return 64;
        return v;
    endfunction

    // hold the request until the block takes it, then idle for the gap given
    task automatic issue_request(logic op, logic [IDX_W-1:0] pg, logic [IDX_W-1:0] sl,
                                 int gap);
        @(negedge clk);
        start      = 1'b1;
        opcode     = op;
        page_index = pg;
        slot_index = sl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic issue_insert(int gap);
        issue_request(OP_INSERT, 6'($urandom), 6'($urandom), gap);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_slots_per_page(int v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = 7'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin : stimulus
        int spp_tab  [PHASES];
        int idle_tab [PHASES];
        int ins_tab  [PHASES];
        int spp;
        int n;
        int sl_top;
        logic [IDX_W-1:0] pg;
        logic [IDX_W-1:0] sl;

        spp_tab  = '{8, 0, 64, 65, 3, 1, -1};
        idle_tab = '{0, 70, 10, 0, 70, 10, 0};
        ins_tab  = '{65, 95, 50, 50, 55, 90, 60};

        rst_n      = 1'b0;
        start      = 1'b0;
        opcode     = OP_INSERT;
        page_index = '0;
        slot_index = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // two slots per page: open, fill, free and refill pages
        write_slots_per_page(2);
        issue_request(OP_DELETE, 6'd0, 6'd0, 0);    // nothing opened yet
        issue_insert(0);
        issue_insert(1);                              // page 0 full
        issue_insert(0);                              // opens page 1
        issue_request(OP_DELETE, 6'd0, 6'd1, 0);    // page 0 back on list
        issue_request(OP_DELETE, 6'd0, 6'd1, 2);    // not occupied
        issue_request(OP_DELETE, 6'd0, 6'd2, 0);    // slot past the page size
        issue_request(OP_DELETE, 6'd63, 6'd63, 0);
        issue_insert(0);
        issue_insert(3);
        wait_drained();

        // above the maximum: acts as 64
        write_slots_per_page(127);
        issue_insert(0);
        issue_request(OP_DELETE, 6'd2, 6'd63, 0);
        issue_request(OP_DELETE, 6'd2, 6'd0, 1);
        issue_insert(0);
        wait_drained();

        // lower the size under the head page's count
        write_slots_per_page(1);
        issue_insert(0);
        issue_insert(0);
        issue_request(OP_DELETE, 6'd3, 6'd0, 0);
        issue_request(OP_DELETE, 6'd1, 6'd0, 0);

        for (int p = 0; p < PHASES; p++)
        begin
            spp = (spp_tab[p] < 0) ? $urandom_range(0, 127) : spp_tab[p];
            wait_drained();
            write_slots_per_page(spp);
            n = clamp_slots(spp);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // hold off once mid-phase until every result is back
                if (p == 2 && k == PHASE_ITEMS / 2)
                    wait_drained();
                if ($urandom_range(0, 99) < ins_tab[p])
                begin
                    issue_insert(pick_gap(idle_tab[p]));
                end
                else
                begin
                    if ($urandom_range(0, 99) < 85)
                    begin
                        sl_top = (hi_slot < n - 1) ? hi_slot : n - 1;
                        pg = 6'($urandom_range(0, hi_page));
                        sl = 6'($urandom_range(0, sl_top));
                    end
                    else
                    begin
                        pg = 6'($urandom);
                        sl = 6'($urandom);
                    end
                    issue_request(OP_DELETE, pg, sl, pick_gap(idle_tab[p]));
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/psa_pkg.sv
design/psa_ram.sv
design/psa_update.sv
design/paged_slot_allocator_core.sv
design/psa_checker.sv
tb/psa_alloc_checker.sv
tb/tb.sv
